FILE: hw/rtl/vertex_transform_unit_assert.svh
// Assertion macros used by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_UNIT_ASSERT_SVH
`define VERTEX_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define VTU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define VTU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/vtu_pkg.sv
// Shared types, constants and lane tables of the vertex transform unit.
package vtu_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int IDX_W             = 4;
   localparam int N_ELEM            = 16;
   localparam int N_LANE            = 10;
   localparam int SUM_W             = 2 * DATA_WIDTH + 2;
   localparam int QUEUE_DEPTH       = 4;

   // First lane of each result group.
   localparam int LANE_WORLD  = 0;
   localparam int LANE_CLIP   = 3;
   localparam int LANE_NORMAL = 7;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_VERTEX = 1'b1
   } vtu_op_type;

   typedef enum logic {
      MAT_MODEL = 1'b0,
      MAT_MVP   = 1'b1
   } vtu_mat_type;

   typedef struct packed {
      vtu_op_type                    op;
      vtu_mat_type                   mat;
      logic [IDX_W-1:0]              index;
      logic [DATA_WIDTH-1:0]         value;
      logic [2:0][DATA_WIDTH-1:0]    pos;
      logic [2:0][DATA_WIDTH-1:0]    normal;
   } vtu_entry_type;

   typedef struct packed {
      logic          valid;
      vtu_entry_type entry;
   } vtu_slot_type;

   // Matrix row used by a lane.
   function automatic logic [1:0] lane_row(input int lane);
      if (lane < LANE_CLIP) begin
         return 2'(lane - LANE_WORLD);
      end else if (lane < LANE_NORMAL) begin
         return 2'(lane - LANE_CLIP);
      end
      return 2'(lane - LANE_NORMAL);
   endfunction

   function automatic logic lane_uses_mvp(input int lane);
      return (lane >= LANE_CLIP) && (lane < LANE_NORMAL);
   endfunction

   function automatic logic lane_uses_normal(input int lane);
      return lane >= LANE_NORMAL;
   endfunction

   // Position lanes carry w = 1, normal lanes w = 0.
   function automatic logic lane_has_w(input int lane);
      return lane < LANE_NORMAL;
   endfunction

endpackage

FILE: hw/rtl/vtu_if.sv
// Request and response channel interfaces of the vertex transform unit.
interface vtu_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    req_type;
   logic                                    matrix_select;
   logic [vtu_pkg::IDX_W-1:0]               element_index;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   element_value;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   pos_x;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   pos_y;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   pos_z;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   normal_x;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   normal_y;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   normal_z;

   modport source (
      output valid, req_type, matrix_select, element_index, element_value,
             pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
      input  ready
   );
   modport sink (
      input  valid, req_type, matrix_select, element_index, element_value,
             pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
      output ready
   );
endinterface

interface vtu_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   world_x;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   world_y;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   world_z;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   clip_x;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   clip_y;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   clip_z;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   clip_w;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   world_normal_x;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   world_normal_y;
   logic signed [vtu_pkg::DATA_WIDTH-1:0]   world_normal_z;

   modport source (
      output valid, world_x, world_y, world_z, clip_x, clip_y, clip_z, clip_w,
             world_normal_x, world_normal_y, world_normal_z,
      input  ready
   );
   modport sink (
      input  valid, world_x, world_y, world_z, clip_x, clip_y, clip_z, clip_w,
             world_normal_x, world_normal_y, world_normal_z,
      output ready
   );
endinterface

FILE: hw/rtl/vtu_front.sv
// Front end: accepts requests, classifies them and holds one in a register.
module vtu_front (
   input  logic                  clock,
   input  logic                  reset,
   vtu_req_if.sink               req_bus,
   output vtu_pkg::vtu_slot_type push,
   input  logic                  push_ready
);

   logic                   hold_valid_ff, hold_valid_in;
   vtu_pkg::vtu_entry_type hold_entry_ff, hold_entry_in;
   vtu_pkg::vtu_entry_type classified;
   logic                   accept;

   assign req_bus.ready = !hold_valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      classified.op     = vtu_pkg::vtu_op_type'(req_bus.req_type);
      classified.mat    = vtu_pkg::vtu_mat_type'(req_bus.matrix_select);
      classified.index  = req_bus.element_index;
      classified.value  = req_bus.element_value;
      classified.pos    = {req_bus.pos_z, req_bus.pos_y, req_bus.pos_x};
      classified.normal = {req_bus.normal_z, req_bus.normal_y, req_bus.normal_x};

      hold_valid_in = hold_valid_ff;
      hold_entry_in = hold_entry_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_entry_in = classified;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_entry_ff <= hold_entry_in;
   end

   assign push.valid = hold_valid_ff;
   assign push.entry = hold_entry_ff;

endmodule

FILE: hw/rtl/vtu_queue.sv
// Short request queue between the front end and the transform back end.
module vtu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  vtu_pkg::vtu_slot_type push,
   output logic                  push_ready,
   output vtu_pkg::vtu_slot_type head,
   input  logic                  pop
);

   localparam int DEPTH = vtu_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vtu_pkg::vtu_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign push_fire  = push.valid && push_ready;
   assign head.valid = count_ff != '0;
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: hw/rtl/vtu_back.sv
// Back end: matrix registers and ten pipelined fixed-point dot-product lanes.
`include "vertex_transform_unit_assert.svh"

module vtu_back #(
   parameter int FRAC_BITS = vtu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vtu_pkg::vtu_slot_type head,
   output logic                  pop,
   vtu_rsp_if.source             rsp_bus
);

   localparam int DW    = vtu_pkg::DATA_WIDTH;
   localparam int SW    = vtu_pkg::SUM_W;
   localparam int NL    = vtu_pkg::N_LANE;
   localparam int NE    = vtu_pkg::N_ELEM;
   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   logic signed [DW-1:0] model_ff [NE];
   logic signed [DW-1:0] mvp_ff   [NE];

   logic signed [DW-1:0]   mat_elem [NL][4];
   logic signed [DW-1:0]   vec_elem [NL][3];
   logic signed [2*DW-1:0] prod_ff  [NL][3];
   logic signed [SW-1:0]   bias_ff  [NL];
   logic signed [SW-1:0]   suma_ff  [NL];
   logic signed [SW-1:0]   sumb_ff  [NL];
   logic signed [SW-1:0]   total_ff [NL];
   logic signed [SW-1:0]   shifted  [NL];
   logic signed [DW-1:0]   sat      [NL];
   logic signed [DW-1:0]   result_ff [NL];

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, out_valid_ff, out_valid_in;
   logic adv, launch, is_load;

   assign adv     = !out_valid_ff || rsp_bus.ready;
   assign is_load = head.entry.op == vtu_pkg::OP_LOAD;
   assign pop     = head.valid && (is_load || adv);
   assign launch  = head.valid && !is_load && adv;

   // Matrix loads
   always_ff @(posedge clock) begin
      if (pop && is_load) begin
         if (head.entry.mat == vtu_pkg::MAT_MODEL) begin
            model_ff[head.entry.index] <= $signed(head.entry.value);
         end else begin
            mvp_ff[head.entry.index] <= $signed(head.entry.value);
         end
      end
   end

   // Operand routing per lane
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         for (int c = 0; c < 4; c++) begin
            if (vtu_pkg::lane_uses_mvp(l)) begin
               mat_elem[l][c] = mvp_ff[{vtu_pkg::lane_row(l), 2'(c)}];
            end else begin
               mat_elem[l][c] = model_ff[{vtu_pkg::lane_row(l), 2'(c)}];
            end
         end
         for (int c = 0; c < 3; c++) begin
            if (vtu_pkg::lane_uses_normal(l)) begin
               vec_elem[l][c] = $signed(head.entry.normal[c]);
            end else begin
               vec_elem[l][c] = $signed(head.entry.pos[c]);
            end
         end
      end
   end

   // Shift and saturate
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         shifted[l] = total_ff[l] >>> FRAC_BITS;
         if ((&shifted[l][SW-1:DW-1]) || !(|shifted[l][SW-1:DW-1])) begin
            sat[l] = shifted[l][DW-1:0];
         end else if (shifted[l][SW-1]) begin
            sat[l] = SAT_MIN;
         end else begin
            sat[l] = SAT_MAX;
         end
      end
   end

   always_comb begin
      v1_in        = adv ? launch : v1_ff;
      v2_in        = adv ? v1_ff : v2_ff;
      v3_in        = adv ? v2_ff : v3_ff;
      out_valid_in = adv ? v3_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Multiply, pair add, final add, saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[l][c] <= mat_elem[l][c] * vec_elem[l][c];
            end
            bias_ff[l]   <= vtu_pkg::lane_has_w(l) ?
                            (SW'(mat_elem[l][3]) <<< FRAC_BITS) : '0;
            suma_ff[l]   <= SW'(prod_ff[l][0]) + SW'(prod_ff[l][1]);
            sumb_ff[l]   <= SW'(prod_ff[l][2]) + bias_ff[l];
            total_ff[l]  <= suma_ff[l] + sumb_ff[l];
            result_ff[l] <= sat[l];
         end
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.world_x        = result_ff[vtu_pkg::LANE_WORLD];
   assign rsp_bus.world_y        = result_ff[vtu_pkg::LANE_WORLD + 1];
   assign rsp_bus.world_z        = result_ff[vtu_pkg::LANE_WORLD + 2];
   assign rsp_bus.clip_x         = result_ff[vtu_pkg::LANE_CLIP];
   assign rsp_bus.clip_y         = result_ff[vtu_pkg::LANE_CLIP + 1];
   assign rsp_bus.clip_z         = result_ff[vtu_pkg::LANE_CLIP + 2];
   assign rsp_bus.clip_w         = result_ff[vtu_pkg::LANE_CLIP + 3];
   assign rsp_bus.world_normal_x = result_ff[vtu_pkg::LANE_NORMAL];
   assign rsp_bus.world_normal_y = result_ff[vtu_pkg::LANE_NORMAL + 1];
   assign rsp_bus.world_normal_z = result_ff[vtu_pkg::LANE_NORMAL + 2];

   `VTU_ASSERT_NEXT(a_stall_freezes_pipe, out_valid_ff && !rsp_bus.ready,
      out_valid_ff && v1_ff == $past(v1_ff) && v2_ff == $past(v2_ff) && v3_ff == $past(v3_ff),
      "pipeline moved while response stalled")
   `VTU_ASSERT_NEXT(a_vertex_enters_pipe, pop && head.entry.op == vtu_pkg::OP_VERTEX,
      v1_ff, "popped vertex did not enter pipeline")
   `VTU_ASSERT_NEXT(a_last_stage_fills_out, v3_ff && adv, out_valid_ff,
      "finished vertex lost before output register")

endmodule

FILE: hw/rtl/vertex_transform_unit.sv
// Top level of the vertex transform unit.
//
//   port      dir   handshake      carries
//   req_bus   in    valid/ready    matrix element load or vertex (position, normal)
//   rsp_bus   out   valid/ready    world position, clip coordinates, world normal
//
// One request per cycle, loads and vertices alike, while the response is not stalled;
// thirty 32x32 multipliers. An accepted vertex passes the input register, the queue,
// multiply, pair add, final add, then shift and saturate into the output register.
// Synchronous reset clears only control state; matrices are undefined until loaded.
// A stalled response freezes the back-end pipeline, but loads at the queue head still
// write the matrices; the queue and input register keep taking requests until full.
module vertex_transform_unit #(
   parameter int FRAC_BITS = vtu_pkg::FRAC_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   vtu_req_if.sink    req_bus,
   vtu_rsp_if.source  rsp_bus
);

   vtu_pkg::vtu_slot_type push;
   vtu_pkg::vtu_slot_type head;
   logic                  push_ready;
   logic                  pop;

   vtu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   vtu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   vtu_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
